/* design/hufdec_pkg.sv */
// Shared types and constants for the Huffman tree-walk decoder.
package hufdec_pkg;

   localparam int NODE_W  = 9;   // node index width on the request port
   localparam int SYM_W   = 32;  // symbol width on the response port
   localparam int CODE_W  = 8;   // code byte width
   localparam int COUNT_W = 4;   // bit count width
   localparam int WIDE_W  = 17;  // holds any table depth up to 65536

   localparam logic [COUNT_W-1:0] MAX_BITS = 4'd8;

   // request opcodes
   localparam logic ACT_LOAD   = 1'b0;
   localparam logic ACT_DECODE = 1'b1;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_STEP,
      ST_CHECK,
      ST_FLUSH
   } dec_state_type;

   typedef struct packed {
      logic               action;
      logic [NODE_W-1:0]  node_index;
      logic [NODE_W-1:0]  parent_index;
      logic               has_parent;
      logic               is_right;
      logic [SYM_W-1:0]   node_symbol_in;
      logic [CODE_W-1:0]  code_byte;
      logic [COUNT_W-1:0] bit_count;
      logic               stream_start;
   } req_payload_type;

   typedef struct packed {
      logic [SYM_W-1:0] symbol;
      logic             last_of_run;
   } rsp_payload_type;

endpackage

/* design/huffman_tree_walk_decoder_core.sv */
// Huffman tree-walk decoder: node table, bit sequencer and result register.
//
// A load transaction writes one node into the table: its symbol, and when it
// has a parent inside the table, the parent's left or right link. A decode
// transaction walks the tree with the leading bit_count bits of code_byte, MSB
// first, emitting one response per leaf reached; last_of_run marks the final
// symbol of that byte. A decode does, per code bit, one synchronous read of
// the link tables and then the leaf test, and finally hands off the last
// symbol; a stalled response side holds it in CHECK or FLUSH, and req_ready
// is low until it is back in IDLE. Each symbol is held in a pending register
// until the next leaf or the end of the byte so its last_of_run flag is known.
// After reset the link tables are zeroed by a clearing pass over all NODE_COUNT
// entries, during which no request is taken. Symbols are stored at SYMBOL_BITS
// and zero-extended; a node whose symbol was never loaded reads undefined.
module huffman_tree_walk_decoder_core #(
   parameter int NODE_COUNT  = 512,
   parameter int SYMBOL_BITS = 32
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  hufdec_pkg::req_payload_type req_payload,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output hufdec_pkg::rsp_payload_type rsp_payload
);

   localparam int AW = $clog2(NODE_COUNT);
   localparam logic [AW-1:0] LAST_IDX = AW'(NODE_COUNT - 1);
   localparam logic [hufdec_pkg::WIDE_W-1:0] DEPTH_W = hufdec_pkg::WIDE_W'(NODE_COUNT);

   // node index (request width) to table address
   function automatic logic [AW-1:0] node_addr(input logic [hufdec_pkg::NODE_W-1:0] n);
      logic [hufdec_pkg::WIDE_W-1:0] w;
      w = hufdec_pkg::WIDE_W'(n);
      return w[AW-1:0];
   endfunction

   // node table
   logic [hufdec_pkg::NODE_W-1:0] left_mem  [NODE_COUNT];
   logic [hufdec_pkg::NODE_W-1:0] right_mem [NODE_COUNT];
   logic [SYMBOL_BITS-1:0]        sym_mem   [NODE_COUNT];

   // sequencer and datapath registers
   hufdec_pkg::dec_state_type state_ff, state_in;
   logic [AW-1:0]                   clr_ff, clr_in;
   logic [hufdec_pkg::NODE_W-1:0]   walk_ff, walk_in;
   logic [hufdec_pkg::CODE_W-1:0]   byte_ff, byte_in;
   logic [hufdec_pkg::COUNT_W-1:0]  cnt_ff, cnt_in;
   logic                            pend_vld_ff, pend_vld_in;
   logic [SYMBOL_BITS-1:0]          pend_sym_ff, pend_sym_in;
   logic                            rsp_vld_ff, rsp_vld_in;
   logic [hufdec_pkg::SYM_W-1:0]    rsp_sym_ff, rsp_sym_in;
   logic                            rsp_last_ff, rsp_last_in;

   // registered table read data
   logic [hufdec_pkg::NODE_W-1:0]   rd_left_ff, rd_right_ff;
   logic [SYMBOL_BITS-1:0]          rd_sym_ff;

   logic [AW-1:0]                   rd_addr;
   logic                            lw_en, rw_en, sw_en;
   logic [AW-1:0]                   lw_addr, rw_addr, sw_addr;
   logic [hufdec_pkg::NODE_W-1:0]   lw_data, rw_data;

   logic                            req_fire, rsp_fire, out_free, is_leaf;
   logic                            load_fire, dec_fire, node_ok, parent_ok;
   logic [hufdec_pkg::COUNT_W-1:0]  cnt_sat;
   logic [hufdec_pkg::NODE_W-1:0]   next_node;
   logic                            push, push_last;

   assign req_ready = (state_ff == hufdec_pkg::ST_IDLE);
   assign req_fire  = req_valid & req_ready;
   assign load_fire = req_fire & (req_payload.action == hufdec_pkg::ACT_LOAD);
   assign dec_fire  = req_fire & (req_payload.action == hufdec_pkg::ACT_DECODE);

   assign rsp_valid            = rsp_vld_ff;
   assign rsp_payload.symbol      = rsp_sym_ff;
   assign rsp_payload.last_of_run = rsp_last_ff;
   assign rsp_fire = rsp_vld_ff & rsp_ready;
   // result register can take a new symbol this cycle
   assign out_free = ~rsp_vld_ff | rsp_ready;

   assign node_ok   = hufdec_pkg::WIDE_W'(req_payload.node_index)   < DEPTH_W;
   assign parent_ok = hufdec_pkg::WIDE_W'(req_payload.parent_index) < DEPTH_W;
   assign cnt_sat   = (req_payload.bit_count > hufdec_pkg::MAX_BITS) ?
                      hufdec_pkg::MAX_BITS : req_payload.bit_count;

   // read data always belongs to walk_ff when evaluated in CHECK
   assign is_leaf   = (rd_left_ff == '0) && (rd_right_ff == '0);
   assign next_node = byte_ff[hufdec_pkg::CODE_W-1] ? rd_right_ff : rd_left_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         hufdec_pkg::ST_CLEAR: begin
            if (clr_ff == LAST_IDX) state_in = hufdec_pkg::ST_IDLE;
         end
         hufdec_pkg::ST_IDLE: begin
            if (dec_fire && cnt_sat != '0) state_in = hufdec_pkg::ST_STEP;
         end
         hufdec_pkg::ST_STEP: begin
            state_in = hufdec_pkg::ST_CHECK;
         end
         hufdec_pkg::ST_CHECK: begin
            if (is_leaf && pend_vld_ff && !out_free) state_in = hufdec_pkg::ST_CHECK;
            else if (cnt_ff == '0)                    state_in = hufdec_pkg::ST_FLUSH;
            else                                      state_in = hufdec_pkg::ST_STEP;
         end
         hufdec_pkg::ST_FLUSH: begin
            if (!pend_vld_ff || out_free) state_in = hufdec_pkg::ST_IDLE;
         end
         default: state_in = hufdec_pkg::ST_CLEAR;
      endcase
   end

   // datapath and outputs
   always_comb begin
      clr_in      = clr_ff;
      walk_in     = walk_ff;
      byte_in     = byte_ff;
      cnt_in      = cnt_ff;
      pend_vld_in = pend_vld_ff;
      pend_sym_in = pend_sym_ff;
      rd_addr     = node_addr(walk_ff);
      push        = 1'b0;
      push_last   = 1'b0;
      lw_en       = 1'b0;
      rw_en       = 1'b0;
      sw_en       = 1'b0;
      lw_addr     = node_addr(req_payload.parent_index);
      rw_addr     = node_addr(req_payload.parent_index);
      sw_addr     = node_addr(req_payload.node_index);
      lw_data     = req_payload.node_index;
      rw_data     = req_payload.node_index;
      case (state_ff)
         hufdec_pkg::ST_CLEAR: begin
            clr_in  = clr_ff + 1'b1;
            lw_en   = 1'b1;
            rw_en   = 1'b1;
            lw_addr = clr_ff;
            rw_addr = clr_ff;
            lw_data = '0;
            rw_data = '0;
         end
         hufdec_pkg::ST_IDLE: begin
            if (load_fire && node_ok) begin
               sw_en = 1'b1;
               if (req_payload.has_parent && parent_ok) begin
                  rw_en = req_payload.is_right;
                  lw_en = ~req_payload.is_right;
               end
            end
            if (dec_fire) begin
               byte_in = req_payload.code_byte;
               cnt_in  = cnt_sat;
               if (req_payload.stream_start) begin
                  walk_in = '0;
                  rd_addr = '0;
               end
            end
         end
         hufdec_pkg::ST_STEP: begin
            // follow one link; links always hold in-table nodes
            walk_in = next_node;
            rd_addr = node_addr(next_node);
            byte_in = byte_ff << 1;
            cnt_in  = cnt_ff - 1'b1;
         end
         hufdec_pkg::ST_CHECK: begin
            if (is_leaf && (!pend_vld_ff || out_free)) begin
               push        = pend_vld_ff;
               pend_vld_in = 1'b1;
               pend_sym_in = rd_sym_ff;
               walk_in     = '0;
               rd_addr     = '0;
            end
         end
         hufdec_pkg::ST_FLUSH: begin
            if (pend_vld_ff && out_free) begin
               push        = 1'b1;
               push_last   = 1'b1;
               pend_vld_in = 1'b0;
            end
         end
         default: ;
      endcase

      rsp_vld_in  = rsp_vld_ff;
      rsp_sym_in  = rsp_sym_ff;
      rsp_last_in = rsp_last_ff;
      if (push) begin
         rsp_vld_in  = 1'b1;
         rsp_sym_in  = hufdec_pkg::SYM_W'(pend_sym_ff);
         rsp_last_in = push_last;
      end else if (rsp_fire) begin
         rsp_vld_in  = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= hufdec_pkg::ST_CLEAR;
         clr_ff      <= '0;
         walk_ff     <= '0;
         pend_vld_ff <= 1'b0;
         rsp_vld_ff  <= 1'b0;
      end else begin
         state_ff    <= state_in;
         clr_ff      <= clr_in;
         walk_ff     <= walk_in;
         pend_vld_ff <= pend_vld_in;
         rsp_vld_ff  <= rsp_vld_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      byte_ff     <= byte_in;
      cnt_ff      <= cnt_in;
      pend_sym_ff <= pend_sym_in;
      rsp_sym_ff  <= rsp_sym_in;
      rsp_last_ff <= rsp_last_in;
   end

   // node table: one write and one registered read per array
   always_ff @(posedge clock) begin
      if (lw_en) left_mem[lw_addr] <= lw_data;
      if (rw_en) right_mem[rw_addr] <= rw_data;
      if (sw_en) sym_mem[sw_addr] <= req_payload.node_symbol_in[SYMBOL_BITS-1:0];
      rd_left_ff  <= left_mem[rd_addr];
      rd_right_ff <= right_mem[rd_addr];
      rd_sym_ff   <= sym_mem[rd_addr];
   end

endmodule
